[rtl/windowed_product_moment_mean_defines.svh]
// ----------------------------------------------------------------------------
// Windowed product-moment mean assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// Defining NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PRODUCT_MOMENT_MEAN_DEFINES_SVH
`define WINDOWED_PRODUCT_MOMENT_MEAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition must hold whenever the antecedent holds, in the same cycle.
`define WPMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Condition must hold in the cycle after the antecedent.
`define WPMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WPMM_ASSERT_SAME(label, ante, cons, msg)
`define WPMM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/wpmm_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean package
// Shared widths, register and mode codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package wpmm_pkg;

  localparam int PIX_W     = 16;  // pixel field width on the port
  localparam int POS_W     = 12;  // column and row position
  localparam int WIN_W     = 9;   // window width and height registers
  localparam int OFS_W     = 8;   // offset inside the window
  localparam int WEIGHT_W  = 2 * OFS_W;
  localparam int IMG_W_W   = 13;  // image width register
  localparam int MODE_W    = 3;
  localparam int SUM_W     = 64;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W    = 56;
  localparam int AREA_W    = 17;  // window area, at most 256 * 256
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Weighting modes.
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_X    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_Y    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_XX   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_XY   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_YY   = 3'd5;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIN_LEFT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIN_TOP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIN_WIDTH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WIN_HEIGHT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   win_left;
    logic [POS_W-1:0]   win_top;
    logic [WIN_W-1:0]   win_width;
    logic [WIN_W-1:0]   win_height;
    logic [IMG_W_W-1:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic accept_en;
    logic div_start;
    logic sum_clear;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic frame_done;
    logic div_busy;
    logic div_done;
    logic out_full;
  } dp_stat_t;

endpackage

[rtl/wpmm_if.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean channels
// Valid/ready channels for pixel pairs and for frame results.
// ----------------------------------------------------------------------------
interface wpmm_pair_if;
  logic                       valid;
  logic                       ready;
  logic [wpmm_pkg::PIX_W-1:0] pixel_a;
  logic [wpmm_pkg::PIX_W-1:0] pixel_b;
  logic                       frame_end;

  modport source (output valid, pixel_a, pixel_b, frame_end, input ready);
  modport sink   (input valid, pixel_a, pixel_b, frame_end, output ready);
endinterface

interface wpmm_mean_if;
  logic                        valid;
  logic                        ready;
  logic [wpmm_pkg::MEAN_W-1:0] mean_q8;
  logic                        empty_window;

  modport source (output valid, mean_q8, empty_window, input ready);
  modport sink   (input valid, mean_q8, empty_window, output ready);
endinterface

[rtl/windowed_product_moment_mean.sv]
// Throughput: one pixel-pair transaction per cycle while a frame streams in.
// After the frame-end transaction the product pipeline drains, then the
// 72-step bit-serial divider works out the mean, which moves into the output
// register; with a zero-area window the divider skips the long division. No
// input is taken in that span. Reset restores the register defaults and
// clears the sum and the raster position; there is no clearing pass.
// ----------------------------------------------------------------------------
// Windowed product-moment mean (top level)
// Accumulates weighted pixel-pair products inside a window and reports their
// mean with eight fraction bits at each frame end.
// ----------------------------------------------------------------------------
//
// Pixel pairs arrive in raster order on the pixels channel. The datapath
// tracks the column and row of each pair, tests it against the configured
// window and, for pairs inside it, forms the pixel product and a weight of
// 1, x, y, x*x, x*y or y*y, where x and y are the offsets inside the window.
// The weighted term is built over two registered multiply stages and summed
// in a saturating 64-bit accumulator.
//
// When the frame-end transaction has been taken, the controller stops taking
// input, lets the product pipeline drain and starts the divider, which works
// out sum * 256 / area one quotient bit per cycle and saturates the result to
// 56 bits. The accumulator clears in the same cycle. A zero window area is
// reported through empty_window with a mean of zero.
//
// The result sits in an output register, so a new frame may stream in while
// it waits to be taken; a second result waits in the divider until the output
// register is free.
`include "windowed_product_moment_mean_defines.svh"

module windowed_product_moment_mean #(
  parameter int MAX_WINDOW      = 256,
  parameter int MAX_IMAGE_WIDTH = 4096,
  parameter int PIXEL_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wpmm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpmm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpmm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  wpmm_pair_if.sink                           pixels,
  wpmm_mean_if.source                         result
);

  wpmm_pkg::cfg_t      cfg;
  wpmm_pkg::dp_cmd_t   ctrl_cmd;
  wpmm_pkg::dp_stat_t  dp_stat;

  // Configuration registers; the user must write them only while no frame is in flight; the block does not enforce it.
  wpmm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpmm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (dp_stat),
    .cmd  (ctrl_cmd)
  );

  // Input is taken only while the controller is accumulating.
  assign pixels.ready = ctrl_cmd.accept_en;

  wpmm_dp #(
    .MAX_WINDOW      (MAX_WINDOW),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (ctrl_cmd),
    .stat         (dp_stat),
    .in_valid     (pixels.valid),
    .pixel_a      (pixels.pixel_a),
    .pixel_b      (pixels.pixel_b),
    .frame_end    (pixels.frame_end),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .mean_q8      (result.mean_q8),
    .empty_window (result.empty_window)
  );

  // The frame-end transaction must close the input until the mean is done.
  `WPMM_ASSERT_NEXT(a_frame_end_blocks, pixels.valid && pixels.ready && pixels.frame_end, !pixels.ready, "input still open after frame end")
  // No pixel may be taken while the divider holds the previous frame's sum.
  `WPMM_ASSERT_SAME(a_no_input_in_div, dp_stat.div_busy, !pixels.ready, "input taken during division")
  // The divider may only sample the sum once every term has landed.
  `WPMM_ASSERT_SAME(a_start_after_drain, ctrl_cmd.div_start, !dp_stat.pipe_busy, "division started with terms in flight")
  // A waiting result must never be overwritten.
  `WPMM_ASSERT_SAME(a_no_overwrite, ctrl_cmd.out_load, !result.valid || result.ready, "result overwritten")

endmodule

[rtl/wpmm_regs.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module wpmm_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wpmm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpmm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpmm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output wpmm_pkg::cfg_t                      cfg
);

  logic                               wr_en;
  logic [wpmm_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[wpmm_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= wpmm_pkg::MODE_NONE;
      cfg.win_left    <= '0;
      cfg.win_top     <= '0;
      cfg.win_width   <= '0;
      cfg.win_height  <= '0;
      cfg.image_width <= wpmm_pkg::IMG_W_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        wpmm_pkg::REG_MODE:        cfg.mode        <= pwdata[wpmm_pkg::MODE_W-1:0];
        wpmm_pkg::REG_WIN_LEFT:    cfg.win_left    <= pwdata[wpmm_pkg::POS_W-1:0];
        wpmm_pkg::REG_WIN_TOP:     cfg.win_top     <= pwdata[wpmm_pkg::POS_W-1:0];
        wpmm_pkg::REG_WIN_WIDTH:   cfg.win_width   <= pwdata[wpmm_pkg::WIN_W-1:0];
        wpmm_pkg::REG_WIN_HEIGHT:  cfg.win_height  <= pwdata[wpmm_pkg::WIN_W-1:0];
        wpmm_pkg::REG_IMAGE_WIDTH: cfg.image_width <= pwdata[wpmm_pkg::IMG_W_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wpmm_pkg::REG_MODE:        prdata = wpmm_pkg::APB_DATA_W'(cfg.mode);
      wpmm_pkg::REG_WIN_LEFT:    prdata = wpmm_pkg::APB_DATA_W'(cfg.win_left);
      wpmm_pkg::REG_WIN_TOP:     prdata = wpmm_pkg::APB_DATA_W'(cfg.win_top);
      wpmm_pkg::REG_WIN_WIDTH:   prdata = wpmm_pkg::APB_DATA_W'(cfg.win_width);
      wpmm_pkg::REG_WIN_HEIGHT:  prdata = wpmm_pkg::APB_DATA_W'(cfg.win_height);
      wpmm_pkg::REG_IMAGE_WIDTH: prdata = wpmm_pkg::APB_DATA_W'(cfg.image_width);
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/wpmm_div.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean divider
// Restoring divider, one quotient bit per cycle, of sum * 256 by the area.
// ----------------------------------------------------------------------------
module wpmm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wpmm_pkg::SUM_W-1:0]    sum,
  input  logic [wpmm_pkg::AREA_W-1:0]   area,
  output logic                          busy,
  output logic                          done,
  output logic [wpmm_pkg::MEAN_W-1:0]   mean,
  output logic                          empty
);

  localparam int DVD_W = wpmm_pkg::SUM_W + wpmm_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int REM_W = wpmm_pkg::AREA_W - 1;

  logic [CNT_W-1:0]            cnt;
  logic [DVD_W-1:0]            dvd;
  logic [REM_W-1:0]            rem;
  logic [wpmm_pkg::AREA_W-1:0] divisor;
  logic [wpmm_pkg::AREA_W-1:0] trial;
  logic                        q_bit;
  logic [REM_W-1:0]            rem_next;

  // The partial remainder stays below the divisor, so it fits one bit less.
  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    q_bit    = (trial >= divisor);
    rem_next = q_bit ? REM_W'(trial - divisor) : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= (area == '0) ? CNT_W'(1) : CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= {sum, wpmm_pkg::FRAC_BITS'(0)};
      rem     <= '0;
      divisor <= area;
      empty   <= (area == '0);
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  // Quotients that do not fit the result saturate to all ones.
  always_comb begin
    if (empty) begin
      mean = '0;
    end else if (|dvd[DVD_W-1:wpmm_pkg::MEAN_W]) begin
      mean = '1;
    end else begin
      mean = dvd[wpmm_pkg::MEAN_W-1:0];
    end
  end

endmodule

[rtl/wpmm_dp.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean datapath
// Position tracking, window test, product pipeline, accumulator, divider and
// output register.
// ----------------------------------------------------------------------------
module wpmm_dp #(
  parameter int MAX_WINDOW      = 256,
  parameter int MAX_IMAGE_WIDTH = 4096,
  parameter int PIXEL_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wpmm_pkg::cfg_t                cfg,
  input  wpmm_pkg::dp_cmd_t             cmd,
  output wpmm_pkg::dp_stat_t            stat,
  input  logic                          in_valid,
  input  logic [wpmm_pkg::PIX_W-1:0]    pixel_a,
  input  logic [wpmm_pkg::PIX_W-1:0]    pixel_b,
  input  logic                          frame_end,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [wpmm_pkg::MEAN_W-1:0]   mean_q8,
  output logic                          empty_window
);

  localparam int PROD_W = 2 * PIXEL_BITS;
  localparam int TERM_W = PROD_W + wpmm_pkg::WEIGHT_W;
  localparam logic [wpmm_pkg::WIN_W-1:0]   WIN_CLAMP = wpmm_pkg::WIN_W'(MAX_WINDOW);
  localparam logic [wpmm_pkg::IMG_W_W-1:0] IMG_CLAMP = wpmm_pkg::IMG_W_W'(MAX_IMAGE_WIDTH);

  logic                              fire;
  logic [wpmm_pkg::WIN_W-1:0]        ww;
  logic [wpmm_pkg::WIN_W-1:0]        wh;
  logic [wpmm_pkg::IMG_W_W-1:0]      iw;
  logic [wpmm_pkg::POS_W-1:0]        col;
  logic [wpmm_pkg::POS_W-1:0]        row;
  logic [wpmm_pkg::POS_W-1:0]        col_next;
  logic [wpmm_pkg::POS_W-1:0]        row_next;
  logic [wpmm_pkg::IMG_W_W-1:0]      col_inc;
  logic [wpmm_pkg::POS_W-1:0]        col_ofs;
  logic [wpmm_pkg::POS_W-1:0]        row_ofs;
  logic                              in_win;
  logic [wpmm_pkg::OFS_W-1:0]        x;
  logic [wpmm_pkg::OFS_W-1:0]        y;
  logic [wpmm_pkg::WEIGHT_W-1:0]     weight;
  logic                              v1;
  logic [PROD_W-1:0]                 ab;
  logic [wpmm_pkg::WEIGHT_W-1:0]     w1;
  logic                              v2;
  logic [TERM_W-1:0]                 term;
  logic [wpmm_pkg::SUM_W-1:0]        sum;
  logic [wpmm_pkg::SUM_W:0]          sum_add;
  logic [wpmm_pkg::AREA_W-1:0]       area;
  logic                              div_busy;
  logic                              div_done;
  logic [wpmm_pkg::MEAN_W-1:0]       div_mean;
  logic                              div_empty;

  assign fire = cmd.accept_en & in_valid;

  always_comb begin
    ww = (cfg.win_width  > WIN_CLAMP) ? WIN_CLAMP : cfg.win_width;
    wh = (cfg.win_height > WIN_CLAMP) ? WIN_CLAMP : cfg.win_height;
    if (cfg.image_width == '0) begin
      iw = wpmm_pkg::IMG_W_W'(1);
    end else if (cfg.image_width > IMG_CLAMP) begin
      iw = IMG_CLAMP;
    end else begin
      iw = cfg.image_width;
    end
  end

  // Window test and offsets; an offset inside the window is below 256.
  always_comb begin
    col_ofs = col - cfg.win_left;
    row_ofs = row - cfg.win_top;
    in_win  = (col >= cfg.win_left) && (col_ofs < wpmm_pkg::POS_W'(ww)) &&
              (row >= cfg.win_top)  && (row_ofs < wpmm_pkg::POS_W'(wh));
    x = col_ofs[wpmm_pkg::OFS_W-1:0];
    y = row_ofs[wpmm_pkg::OFS_W-1:0];
    case (cfg.mode)
      wpmm_pkg::MODE_X:  weight = wpmm_pkg::WEIGHT_W'(x);
      wpmm_pkg::MODE_Y:  weight = wpmm_pkg::WEIGHT_W'(y);
      wpmm_pkg::MODE_XX: weight = wpmm_pkg::WEIGHT_W'(x) * wpmm_pkg::WEIGHT_W'(x);
      wpmm_pkg::MODE_XY: weight = wpmm_pkg::WEIGHT_W'(x) * wpmm_pkg::WEIGHT_W'(y);
      wpmm_pkg::MODE_YY: weight = wpmm_pkg::WEIGHT_W'(y) * wpmm_pkg::WEIGHT_W'(y);
      default:           weight = wpmm_pkg::WEIGHT_W'(1);
    endcase
  end

  // Raster position; the last pair of a frame restarts at the origin.
  always_comb begin
    col_inc  = {1'b0, col} + wpmm_pkg::IMG_W_W'(1);
    col_next = col_inc[wpmm_pkg::POS_W-1:0];
    row_next = row;
    if (frame_end) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= iw) begin
      col_next = '0;
      row_next = row + wpmm_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Product pipeline: pixel product and weight, then weighted term.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= fire & in_win;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ab   <= PROD_W'(pixel_a[PIXEL_BITS-1:0]) * PROD_W'(pixel_b[PIXEL_BITS-1:0]);
    w1   <= weight;
    term <= TERM_W'(ab) * TERM_W'(w1);
  end

  // Saturating accumulator.
  assign sum_add = {1'b0, sum} + (wpmm_pkg::SUM_W + 1)'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.sum_clear) begin
      sum <= '0;
    end else if (v2) begin
      sum <= sum_add[wpmm_pkg::SUM_W] ? '1 : sum_add[wpmm_pkg::SUM_W-1:0];
    end
  end

  assign area = wpmm_pkg::AREA_W'(ww) * wpmm_pkg::AREA_W'(wh);

  wpmm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .sum   (sum),
    .area  (area),
    .busy  (div_busy),
    .done  (div_done),
    .mean  (div_mean),
    .empty (div_empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_q8      <= div_mean;
      empty_window <= div_empty;
    end
  end

  always_comb begin
    stat.pipe_busy  = v1 | v2;
    stat.frame_done = fire & frame_end;
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.out_full   = out_valid;
  end

endmodule

[rtl/wpmm_ctrl.sv]
// ----------------------------------------------------------------------------
// Windowed product-moment mean controller
// Sequences accumulation, pipeline drain, division and result hand-off.
// ----------------------------------------------------------------------------
module wpmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  wpmm_pkg::dp_stat_t  stat,
  output wpmm_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_ACCUM = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.accept_en = 1'b0;
    cmd.div_start = 1'b0;
    cmd.sum_clear = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      S_ACCUM: begin
        cmd.accept_en = 1'b1;
        if (stat.frame_done) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The divider takes the sum in the same cycle the accumulator clears.
        if (!stat.pipe_busy) begin
          cmd.div_start = 1'b1;
          cmd.sum_clear = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.out_full) begin
            state_next = S_HOLD;
          end else begin
            cmd.out_load = 1'b1;
            state_next   = S_ACCUM;
          end
        end
      end
      S_HOLD: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACCUM;
        end
      end
      default: begin
        state_next = S_ACCUM;
      end
    endcase
  end

endmodule

[verif/tb_windowed_product_moment_mean.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed product-moment mean testbench
// Streams pixel-pair frames through the block under a range of window, image
// and weighting settings. A software copy of the accumulator, fed with each taken
// pair, predicts each frame mean, and every result transaction is checked against it.
// ----------------------------------------------------------------------------
module tb_windowed_product_moment_mean;

  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 5;
  // Long enough to cover the divider and the product pipeline with room to
  // spare.
  localparam int DRAIN_CYCLES    = 100;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int REPORT_LIMIT    = 10;
  localparam int WINDOW_CAP      = 256;
  localparam int IMAGE_WIDTH_CAP = 4096;
  localparam int SEGMENT_PAIRS   = 80;
  localparam int SEGMENTS        = 5;
  localparam int BACKLOG_HOLD    = 2000;
  localparam int SCALED_W        = wpmm_pkg::SUM_W + wpmm_pkg::FRAC_BITS;
  localparam logic [wpmm_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [wpmm_pkg::MEAN_W-1:0] MEAN_CEILING  = '1;
  localparam logic [wpmm_pkg::PIX_W-1:0]  PIXEL_FULL    = '1;

  typedef struct packed {
    logic [wpmm_pkg::MEAN_W-1:0] mean_q8;
    logic                        empty_window;
  } frame_mean_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [wpmm_pkg::APB_ADDR_W-1:0] paddr;
  logic [wpmm_pkg::APB_DATA_W-1:0] pwdata;
  logic [wpmm_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  wpmm_pair_if pixels_ch ();
  wpmm_mean_if result_ch ();

  windowed_product_moment_mean dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pixels (pixels_ch),
    .result (result_ch)
  );

  // Software copy of the register file and of the accumulator state.
  wpmm_pkg::cfg_t             shadow_cfg = '{mode: wpmm_pkg::MODE_NONE, win_left: '0,
                                             win_top: '0, win_width: '0, win_height: '0,
                                             image_width: wpmm_pkg::IMG_W_W'(1)};
  logic [wpmm_pkg::SUM_W-1:0] acc_sum = '0;
  logic [wpmm_pkg::POS_W-1:0] acc_col = '0;
  logic [wpmm_pkg::POS_W-1:0] acc_row = '0;

  // Frame means predicted but not yet seen on the result channel, oldest first.
  frame_mean_t pending_means[$];

  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // The run is cut off and reported as failing once the cycle count passes its limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver. A long hold-off, when requested, takes precedence over
  // the random stalls so that the block backs up all the way to its input.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold         <= rx_hold - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Advances the accumulator by one accepted pixel pair, in the same way the
  // block does, and queues the frame mean when the pair closes a frame.
  function automatic void accumulate_pair(input logic [wpmm_pkg::PIX_W-1:0] a,
                                          input logic [wpmm_pkg::PIX_W-1:0] b,
                                          input logic                       last);
    int                          ww;
    int                          wh;
    int                          iw;
    int                          dx;
    int                          dy;
    int                          weight;
    logic [wpmm_pkg::SUM_W-1:0]  term;
    logic [wpmm_pkg::AREA_W-1:0] area;
    logic [SCALED_W-1:0]         scaled;
    frame_mean_t                 res;
    // Oversized windows and image widths are clamped; a zero width means one.
    ww = (shadow_cfg.win_width > WINDOW_CAP) ? WINDOW_CAP : int'(shadow_cfg.win_width);
    wh = (shadow_cfg.win_height > WINDOW_CAP) ? WINDOW_CAP : int'(shadow_cfg.win_height);
    iw = int'(shadow_cfg.image_width);
    if (iw == 0) iw = 1;
    if (iw > IMAGE_WIDTH_CAP) iw = IMAGE_WIDTH_CAP;

    dx = int'(acc_col) - int'(shadow_cfg.win_left);
    dy = int'(acc_row) - int'(shadow_cfg.win_top);
    if (dx >= 0 && dx < ww && dy >= 0 && dy < wh) begin
      case (shadow_cfg.mode)
        wpmm_pkg::MODE_X:  weight = dx;
        wpmm_pkg::MODE_Y:  weight = dy;
        wpmm_pkg::MODE_XX: weight = dx * dx;
        wpmm_pkg::MODE_XY: weight = dx * dy;
        wpmm_pkg::MODE_YY: weight = dy * dy;
        default:           weight = 1;
      endcase
      term = wpmm_pkg::SUM_W'(a) * wpmm_pkg::SUM_W'(b) * wpmm_pkg::SUM_W'(weight);
      // The sum sticks at all ones instead of wrapping.
      if (acc_sum > ~term) acc_sum = '1;
      else acc_sum = acc_sum + term;
    end

    // Raster position; the row counter wraps at its width.
    if (int'(acc_col) + 1 >= iw) begin
      acc_col = '0;
      acc_row = acc_row + wpmm_pkg::POS_W'(1);
    end else begin
      acc_col = acc_col + wpmm_pkg::POS_W'(1);
    end

    if (!last) return;

    area = wpmm_pkg::AREA_W'(ww * wh);
    if (area == '0) begin
      res.mean_q8      = '0;
      res.empty_window = 1'b1;
    end else begin
      // Truncating division of the sum with eight fraction bits appended,
      // saturated to the width of the mean.
      scaled           = {acc_sum, {wpmm_pkg::FRAC_BITS{1'b0}}} / SCALED_W'(area);
      res.mean_q8      = (|scaled[SCALED_W-1:wpmm_pkg::MEAN_W]) ? MEAN_CEILING :
                         scaled[wpmm_pkg::MEAN_W-1:0];
      res.empty_window = 1'b0;
    end
    pending_means.push_back(res);
    acc_sum = '0;
    acc_col = '0;
    acc_row = '0;
  endfunction

  // Every pixel-pair transaction feeds the predictor at the edge it is taken.
  always @(posedge clk) begin
    if (!rst && pixels_ch.valid && pixels_ch.ready) begin
      accumulate_pair(pixels_ch.pixel_a, pixels_ch.pixel_b, pixels_ch.frame_end);
    end
  end

  // Every result transaction is compared with the oldest pending mean.
  always @(posedge clk) begin : check_means
    frame_mean_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result with nothing pending: mean_q8=%0h empty_window=%0b",
                   result_ch.mean_q8, result_ch.empty_window);
        end
      end else begin
        want = pending_means.pop_front();
        if (result_ch.mean_q8 !== want.mean_q8 ||
            result_ch.empty_window !== want.empty_window) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mean mismatch: expected mean_q8=%0h empty_window=%0b, got %0h %0b",
                     want.mean_q8, want.empty_window,
                     result_ch.mean_q8, result_ch.empty_window);
          end
        end
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready. The shadow copy
  // changes at the edge where the block takes the write.
  task automatic write_reg(input logic [wpmm_pkg::REG_IDX_W-1:0]  idx,
                           input logic [wpmm_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      wpmm_pkg::REG_MODE:        shadow_cfg.mode        = value[wpmm_pkg::MODE_W-1:0];
      wpmm_pkg::REG_WIN_LEFT:    shadow_cfg.win_left    = value[wpmm_pkg::POS_W-1:0];
      wpmm_pkg::REG_WIN_TOP:     shadow_cfg.win_top     = value[wpmm_pkg::POS_W-1:0];
      wpmm_pkg::REG_WIN_WIDTH:   shadow_cfg.win_width   = value[wpmm_pkg::WIN_W-1:0];
      wpmm_pkg::REG_WIN_HEIGHT:  shadow_cfg.win_height  = value[wpmm_pkg::WIN_W-1:0];
      wpmm_pkg::REG_IMAGE_WIDTH: shadow_cfg.image_width = value[wpmm_pkg::IMG_W_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register value, optionally with random bits above the field, which the
  // block must drop.
  function automatic logic [wpmm_pkg::APB_DATA_W-1:0] field_value(input int unsigned v,
                                                                  input int width,
                                                                  input bit junk);
    logic [wpmm_pkg::APB_DATA_W-1:0] word;
    word = wpmm_pkg::APB_DATA_W'(v);
    if (junk) word = word | (wpmm_pkg::APB_DATA_W'($urandom) << width);
    return word;
  endfunction

  task automatic configure(input int unsigned mode_v, input int unsigned left_v,
                           input int unsigned top_v, input int unsigned wide_v,
                           input int unsigned tall_v, input int unsigned image_v,
                           input bit junk);
    write_reg(wpmm_pkg::REG_MODE,        field_value(mode_v,  wpmm_pkg::MODE_W,  junk));
    write_reg(wpmm_pkg::REG_WIN_LEFT,    field_value(left_v,  wpmm_pkg::POS_W,   junk));
    write_reg(wpmm_pkg::REG_WIN_TOP,     field_value(top_v,   wpmm_pkg::POS_W,   junk));
    write_reg(wpmm_pkg::REG_WIN_WIDTH,   field_value(wide_v,  wpmm_pkg::WIN_W,   junk));
    write_reg(wpmm_pkg::REG_WIN_HEIGHT,  field_value(tall_v,  wpmm_pkg::WIN_W,   junk));
    write_reg(wpmm_pkg::REG_IMAGE_WIDTH, field_value(image_v, wpmm_pkg::IMG_W_W, junk));
  endtask

  // Offers one pixel pair and returns at the edge where it is taken. Idle
  // cycles are inserted before the offer at the current sender rate.
  task automatic send_pair(input logic [wpmm_pkg::PIX_W-1:0] a,
                           input logic [wpmm_pkg::PIX_W-1:0] b,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pixels_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixels_ch.valid     <= 1'b1;
    pixels_ch.pixel_a   <= a;
    pixels_ch.pixel_b   <= b;
    pixels_ch.frame_end <= last;
    do @(posedge clk); while (!pixels_ch.ready);
  endtask

  // Pixel values lean toward the two extremes now and then.
  function automatic logic [wpmm_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PIXEL_FULL;
      2:       return wpmm_pkg::PIX_W'($urandom_range(15));
      default: return wpmm_pkg::PIX_W'($urandom_range(65535));
    endcase
  endfunction

  // Sends count pairs of random pixels; the last one ends the frame if close
  // is set.
  task automatic send_frame(input int count, input bit close);
    for (int i = 0; i < count; i++) begin
      send_pair(pick_pixel(), pick_pixel(), close && (i == count - 1));
    end
  endtask

  // Stops offering pairs, waits for every pending mean, then lets the block
  // settle so that nothing is in flight when the registers change.
  task automatic wait_drained();
    @(negedge clk);
    pixels_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // With the reset settings the window has no area, so a frame reports an
  // empty window and a zero mean.
  task automatic test_reset_defaults();
    send_frame(3, 1'b1);
    wait_drained();
  endtask

  // Pixel extremes and mixed patterns in a 4 x 2 window, then a frame made of
  // a single pair.
  task automatic test_pixel_extremes();
    configure(32'(wpmm_pkg::MODE_NONE), 0, 0, 4, 2, 4, 1'b0);
    send_pair('0, '0, 1'b0);
    send_pair(PIXEL_FULL, PIXEL_FULL, 1'b0);
    send_pair(PIXEL_FULL, '0, 1'b0);
    send_pair('0, PIXEL_FULL, 1'b0);
    send_pair(16'h8000, 16'h0001, 1'b0);
    send_pair(16'h5555, 16'haaaa, 1'b0);
    send_pair(16'h00ff, 16'hff00, 1'b0);
    send_pair(PIXEL_FULL, PIXEL_FULL, 1'b1);
    send_pair(PIXEL_FULL, PIXEL_FULL, 1'b1);
    wait_drained();
  endtask

  // Every mode value, the two unused ones included, on a 2 x 2 window placed
  // off the image corner of a 3 x 3 frame.
  task automatic test_every_mode();
    configure(32'(wpmm_pkg::MODE_NONE), 1, 1, 2, 2, 3, 1'b0);
    for (int m = 0; m < (1 << wpmm_pkg::MODE_W); m++) begin
      write_reg(wpmm_pkg::REG_MODE, wpmm_pkg::APB_DATA_W'(m));
      send_frame(9, 1'b1);
      wait_drained();
    end
  endtask

  // Clamping of the window size and of the image width, and a window that
  // reaches past the right edge of the image.
  task automatic test_window_limits();
    // Zero image width acts as one column; oversized window is 256 x 256.
    configure(32'(wpmm_pkg::MODE_YY), 0, 0, 511, 511, 0, 1'b0);
    send_frame(6, 1'b1);
    wait_drained();
    // Only columns 3 and 4 of a 5-wide image fall into a 10-wide window.
    configure(32'(wpmm_pkg::MODE_XY), 3, 1, 10, 300, 5, 1'b0);
    send_frame(15, 1'b1);
    wait_drained();
  endtask

  // Registers rewritten while a frame is half done take effect from the next
  // pair; the position and the sum carry on.
  task automatic test_mid_frame_config();
    configure(32'(wpmm_pkg::MODE_X), 0, 0, 4, 4, 4, 1'b0);
    send_frame(6, 1'b0);
    wait_drained();
    write_reg(wpmm_pkg::REG_MODE, wpmm_pkg::APB_DATA_W'(wpmm_pkg::MODE_Y));
    write_reg(wpmm_pkg::REG_WIN_LEFT, wpmm_pkg::APB_DATA_W'(1));
    send_frame(6, 1'b1);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while short frames keep coming,
  // so the output register and the divider both fill and the input stalls.
  // The sender then pauses until every mean has been delivered.
  task automatic test_output_backpressure();
    configure(32'(wpmm_pkg::MODE_X), 0, 0, 2, 2, 2, 1'b0);
    @(posedge clk);
    rx_hold = BACKLOG_HOLD;
    for (int k = 0; k < 6; k++) begin
      send_frame(4, 1'b1);
    end
    wait_drained();
  endtask

  // New random settings for one segment of traffic; now and then the minimum
  // or maximum of every register, or a full-size window.
  task automatic randomize_settings();
    int unsigned iw;
    bit          junk;
    junk = ($urandom_range(4) == 0);
    case ($urandom_range(9))
      0: configure(32'(wpmm_pkg::MODE_NONE), 0, 0, 0, 0, 0, junk);
      1: configure(32'(MODE_SPARE_HI), 4095, 4095, 511, 511, 8191, junk);
      2: configure($urandom_range(7), 0, 0, WINDOW_CAP, WINDOW_CAP, IMAGE_WIDTH_CAP, junk);
      default: begin
        iw = $urandom_range(1, 12);
        configure($urandom_range(7), $urandom_range(iw), $urandom_range(3),
                  $urandom_range(iw + 1), $urandom_range(6), iw, junk);
      end
    endcase
  endtask

  // Random frames under four traffic shapes: no idling, a sparse sender, a
  // slow receiver, and light idling on both sides. Most frames are short so
  // that results come often; some segments stop part-way through a frame and
  // the next segment finishes it under new settings.
  task automatic test_random_traffic();
    int src_shape[4];
    int rx_shape[4];
    int sent;
    int len;
    src_shape = '{0, 88, 0, 24};
    rx_shape  = '{0, 0, 88, 24};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_shape[p];
      rx_stall_pct = rx_shape[p];
      for (int s = 0; s < SEGMENTS; s++) begin
        randomize_settings();
        sent = 0;
        while (sent < SEGMENT_PAIRS) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 30);
          send_frame(len, 1'b1);
          sent += len;
        end
        if ($urandom_range(3) == 0) begin
          send_frame($urandom_range(1, 8), 1'b0);
        end
        wait_drained();
      end
    end
    // Close any frame left open by the last segment.
    send_frame(1, 1'b1);
    src_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pixels_ch.valid     = 1'b0;
    pixels_ch.pixel_a   = '0;
    pixels_ch.pixel_b   = '0;
    pixels_ch.frame_end = 1'b0;
    result_ch.ready     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_pixel_extremes();
    test_every_mode();
    test_window_limits();
    test_mid_frame_config();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[windowed_product_moment_mean.f]
+incdir+rtl
rtl/wpmm_pkg.sv
rtl/wpmm_if.sv
rtl/wpmm_regs.sv
rtl/wpmm_div.sv
rtl/wpmm_dp.sv
rtl/wpmm_ctrl.sv
rtl/windowed_product_moment_mean.sv
verif/tb_windowed_product_moment_mean.sv
